// ===== design/hsec_pkg.sv =====
package hsec_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int DATA_W        = MAX_DATA_BITS;
  localparam int CHK_W         = 6;
  localparam int CW_W          = DATA_W + CHK_W;
  localparam int CFG_W         = 6;
  localparam int ADDR_W        = 3;
  localparam int PDATA_W       = 32;

  localparam logic [CFG_W-1:0] DATA_WIDTH_RESET = 6'd4;

  // register index, taken from paddr above the byte offset
  localparam logic REG_DATA_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_t;

  // data bit j goes to the j-th position that is not a power of two
  function automatic logic [CW_W-1:0] spread_data(input logic [DATA_W-1:0] d);
    logic [CW_W-1:0] w;
    int nxt;
    w   = '0;
    nxt = 0;
    for (int pos = 1; pos <= CW_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        w[pos-1] = d[nxt];
        nxt++;
      end
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] gather_data(input logic [CW_W-1:0] w);
    logic [DATA_W-1:0] d;
    int nxt;
    d   = '0;
    nxt = 0;
    for (int pos = 1; pos <= CW_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        d[nxt] = w[pos-1];
        nxt++;
      end
    end
    return d;
  endfunction

  // positions whose index has bit i set
  function automatic logic [CW_W-1:0] pos_mask(input int i);
    logic [CW_W-1:0] m;
    m = '0;
    for (int k = 1; k <= CW_W; k++) begin
      m[k-1] = ((k >> i) & 1) != 0;
    end
    return m;
  endfunction

  function automatic logic [CW_W-1:0] insert_checks(input logic [CHK_W-1:0] c);
    logic [CW_W-1:0] w;
    w = '0;
    for (int i = 0; i < CHK_W; i++) begin
      w[(1 << i) - 1] = c[i];
    end
    return w;
  endfunction

endpackage

// ===== design/hamming_sec_encode_check.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------------
// in_      | input     | in_valid / in_stall  | in_kind, in_data_in, in_check_in
// out_     | output    | out_valid / out_stall| out_codeword, out_check_out, out_data_out,
//          |           |                      | out_syndrome, out_status
// cfg_     | input     | apb write/read       | data_width at byte address 0
//
// one item per cycle sustained while out_stall stays low; an accepted item moves
// through the stage registers in turn before out_valid rises
// stages: input register, parity trees and syndrome, correction and gather
// rst_n is synchronous, active low: clears valid bits, data_width back to 4
// a stall on out_ backs up through the stages; empty stages still fill, so
// in_stall rises only once every stage holds an item
module hamming_sec_encode_check
  import hsec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [DATA_W-1:0]   in_data_in,
  input  logic [CHK_W-1:0]    in_check_in,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [CW_W-1:0]     out_codeword,
  output logic [CHK_W-1:0]    out_check_out,
  output logic [DATA_W-1:0]   out_data_out,
  output logic [CHK_W-1:0]    out_syndrome,
  output logic [1:0]          out_status,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [PDATA_W-1:0]  cfg_pwdata,
  output logic [PDATA_W-1:0]  cfg_prdata,
  output logic                cfg_pready
);

  // configuration
  logic [CFG_W-1:0] data_width_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[ADDR_W-1] == REG_DATA_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_width_r <= DATA_WIDTH_RESET;
    end else if (cfg_wr) begin
      data_width_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[ADDR_W-1] == REG_DATA_WIDTH) begin
      cfg_prdata[CFG_W-1:0] = data_width_r;
    end
  end

  // widths in use
  logic [CFG_W-1:0]  n_use;
  logic [2:0]        p_use;
  logic [CHK_W-1:0]  len;
  logic [CHK_W-1:0]  pmask;
  logic [DATA_W-1:0] dmask;

  always_comb begin
    if (data_width_r == '0) begin
      n_use = CFG_W'(1);
    end else if (data_width_r > CFG_W'(MAX_DATA_BITS)) begin
      n_use = CFG_W'(MAX_DATA_BITS);
    end else begin
      n_use = data_width_r;
    end
    // smallest p with 2^p >= n + p + 1
    if (n_use <= 6'd1) begin
      p_use = 3'd2;
    end else if (n_use <= 6'd4) begin
      p_use = 3'd3;
    end else if (n_use <= 6'd11) begin
      p_use = 3'd4;
    end else if (n_use <= 6'd26) begin
      p_use = 3'd5;
    end else begin
      p_use = 3'd6;
    end
    len   = n_use + CHK_W'(p_use);
    pmask = ~({CHK_W{1'b1}} << p_use);
    dmask = ~({DATA_W{1'b1}} << n_use);
  end

  // handshake through the stages
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_rdy, s2_rdy, o_rdy;

  assign o_rdy    = !out_v_r || !out_stall;
  assign s2_rdy   = !s2_v_r || o_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (o_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // stage 1: mask and spread the data
  kind_t            s1_kind_r, s1_kind_nxt;
  logic [CW_W-1:0]  s1_word_r, s1_word_nxt;
  logic [CHK_W-1:0] s1_chk_r, s1_chk_nxt;

  always_comb begin
    s1_kind_nxt = kind_t'(in_kind);
    s1_word_nxt = spread_data(in_data_in & dmask);
    s1_chk_nxt  = in_check_in & pmask;
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_kind_r <= s1_kind_nxt;
      s1_word_r <= s1_word_nxt;
      s1_chk_r  <= s1_chk_nxt;
    end
  end

  // stage 2: parity trees, syndrome, check bits into the word
  kind_t            s2_kind_r;
  logic [CW_W-1:0]  s2_word_r, s2_word_nxt;
  logic [CHK_W-1:0] s2_chk_r, s2_chk_nxt;
  logic [CHK_W-1:0] s2_syn_r, s2_syn_nxt;

  always_comb begin
    for (int i = 0; i < CHK_W; i++) begin
      s2_chk_nxt[i] = (^(s1_word_r & pos_mask(i))) & pmask[i];
    end
    if (s1_kind_r == KIND_CHECK) begin
      s2_syn_nxt  = s2_chk_nxt ^ s1_chk_r;
      s2_word_nxt = s1_word_r | insert_checks(s1_chk_r);
    end else begin
      s2_syn_nxt  = '0;
      s2_word_nxt = s1_word_r | insert_checks(s2_chk_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      s2_kind_r <= s1_kind_r;
      s2_word_r <= s2_word_nxt;
      s2_chk_r  <= s2_chk_nxt;
      s2_syn_r  <= s2_syn_nxt;
    end
  end

  // stage 3: flip the bit at the syndrome position, gather data
  logic [CW_W-1:0]   o_word_r, o_word_nxt;
  logic [CHK_W-1:0]  o_chk_r;
  logic [DATA_W-1:0] o_data_r, o_data_nxt;
  logic [CHK_W-1:0]  o_syn_r;
  status_t           o_status_r, o_status_nxt;
  logic              syn_in_range;

  always_comb begin
    syn_in_range = (s2_syn_r <= len);
    o_word_nxt   = s2_word_r;
    o_status_nxt = ST_NONE;
    if (s2_kind_r == KIND_CHECK && s2_syn_r != '0) begin
      if (syn_in_range) begin
        o_word_nxt   = s2_word_r ^ ({{(CW_W-1){1'b0}}, 1'b1} << (s2_syn_r - 1'b1));
        o_status_nxt = ST_CORRECTED;
      end else begin
        o_status_nxt = ST_OUTSIDE;
      end
    end
    o_data_nxt = gather_data(o_word_nxt) & dmask;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && o_rdy) begin
      o_word_r   <= o_word_nxt;
      o_chk_r    <= s2_chk_r;
      o_data_r   <= o_data_nxt;
      o_syn_r    <= s2_syn_r;
      o_status_r <= o_status_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_codeword  = o_word_r;
  assign out_check_out = o_chk_r;
  assign out_data_out  = o_data_r;
  assign out_syndrome  = o_syn_r;
  assign out_status    = o_status_r;

  // checks that an accepted item reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##3 out_valid)
    else $error("accepted item did not reach the output");

  a_none_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_syndrome == '0)
    else $error("no-error status with nonzero syndrome");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CORRECTED |-> out_syndrome != '0 && out_syndrome <= len)
    else $error("corrected status with syndrome outside codeword");

  a_outside_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OUTSIDE |-> out_syndrome > len)
    else $error("outside status with syndrome inside codeword");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hsec_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT     = 18;

  typedef struct packed {
    logic [CW_W-1:0]   codeword;
    logic [CHK_W-1:0]  check;
    logic [DATA_W-1:0] data;
    logic [CHK_W-1:0]  syndrome;
    status_t           status;
  } hamming_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic [DATA_W-1:0]  in_data_in = '0;
  logic [CHK_W-1:0]   in_check_in = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CW_W-1:0]    out_codeword;
  logic [CHK_W-1:0]   out_check_out;
  logic [DATA_W-1:0]  out_data_out;
  logic [CHK_W-1:0]   out_syndrome;
  logic [1:0]         out_status;

  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  // shadow of the data_width register
  logic [CFG_W-1:0]   width_reg = DATA_WIDTH_RESET;
  hamming_result_t    expected_words[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 steady = 1'b0;

  hamming_sec_encode_check i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_data_in    (in_data_in),
    .in_check_in   (in_check_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_codeword  (out_codeword),
    .out_check_out (out_check_out),
    .out_data_out  (out_data_out),
    .out_syndrome  (out_syndrome),
    .out_status    (out_status),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // width 0 acts as 1, anything above the maximum acts as the maximum
  function automatic int eff_width();
    int n;
    n = width_reg;
    if (n < 1) n = 1;
    if (n > MAX_DATA_BITS) n = MAX_DATA_BITS;
    return n;
  endfunction

  function automatic int check_bits(input int n);
    int p;
    p = 0;
    while (p < 7 && (1 << p) < n + p + 1) p++;
    return p;
  endfunction

  function automatic hamming_result_t compute_hamming(input kind_t k,
                                                      input logic [DATA_W-1:0] d,
                                                      input logic [CHK_W-1:0] c);
    hamming_result_t r;
    int n, p, len, nxt, syn;
    logic [CW_W-1:0] word;
    logic [CHK_W-1:0] par, pmask;
    logic [DATA_W-1:0] dmask, data;
    n     = eff_width();
    p     = check_bits(n);
    len   = n + p;
    pmask = CHK_W'((1 << p) - 1);
    dmask = '0;
    for (int i = 0; i < n; i++) dmask[i] = 1'b1;
    data = d & dmask;
    word = '0;
    nxt  = 0;
    for (int pos = 1; pos <= len; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        word[pos-1] = data[nxt];
        nxt++;
      end
    end
    par = '0;
    for (int i = 0; i < p; i++) begin
      for (int pos = 1; pos <= len; pos++) begin
        if (((pos >> i) & 1) != 0) par[i] = par[i] ^ word[pos-1];
      end
    end
    syn      = 0;
    r.status = ST_NONE;
    if (k == KIND_CHECK) begin
      syn = int'((par ^ c) & pmask);
      for (int i = 0; i < p; i++) word[(1 << i) - 1] = c[i];
      if (syn != 0) begin
        if (syn <= len) begin
          word[syn-1] = ~word[syn-1];
          r.status    = ST_CORRECTED;
        end else begin
          r.status = ST_OUTSIDE;
        end
      end
      data = '0;
      nxt  = 0;
      for (int pos = 1; pos <= len; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          data[nxt] = word[pos-1];
          nxt++;
        end
      end
    end else begin
      for (int i = 0; i < p; i++) word[(1 << i) - 1] = par[i];
    end
    r.codeword = word;
    r.check    = par;
    r.data     = data & dmask;
    r.syndrome = CHK_W'(syn);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    hamming_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none got codeword %h", $time,
                 out_codeword);
      end else begin
        want = expected_words.pop_front();
        compare_field("codeword", 64'(want.codeword), 64'(out_codeword));
        compare_field("check_out", 64'(want.check), 64'(out_check_out));
        compare_field("data_out", 64'(want.data), 64'(out_data_out));
        compare_field("syndrome", 64'(want.syndrome), 64'(out_syndrome));
        compare_field("status", 64'(want.status), 64'(out_status));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input kind_t k, input logic [DATA_W-1:0] d,
                           input logic [CHK_W-1:0] c);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= k;
    in_data_in  <= d;
    in_check_in <= c;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(compute_hamming(k, d, c));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // write then read back; upper bus bits are random and must be ignored
  task automatic write_data_width(input logic [CFG_W-1:0] w);
    logic [PDATA_W-1:0] wd;
    wd             = $urandom;
    wd[CFG_W-1:0]  = w;
    cfg_psel      <= 1'b1;
    cfg_pwrite    <= 1'b1;
    cfg_penable   <= 1'b0;
    cfg_paddr     <= {REG_DATA_WIDTH, 2'b00};
    cfg_pwdata    <= wd;
    @(negedge clk);
    cfg_penable   <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    width_reg = w;
    @(negedge clk);
    cfg_pwrite    <= 1'b0;
    cfg_penable   <= 1'b0;
    @(negedge clk);
    cfg_penable   <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[CFG_W-1:0] !== w) begin
      mismatch_count++;
      $display("%0t: data_width readback expected %h got %h", $time, w,
               cfg_prdata[CFG_W-1:0]);
    end
    @(negedge clk);
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
  endtask

  function automatic logic [CHK_W-1:0] encode_checks(input logic [DATA_W-1:0] d);
    hamming_result_t r;
    r = compute_hamming(KIND_ENCODE, d, '0);
    return r.check;
  endfunction

  // some encode requests, mostly codewords with zero, one or two injected errors, some noise
  task automatic send_random_word();
    logic [DATA_W-1:0] d;
    logic [CHK_W-1:0] c, pmask;
    int n, p, pick;
    d = DATA_W'({$urandom, $urandom});
    if ($urandom_range(9) == 0) d = $urandom_range(1) ? '1 : '0;
    n     = eff_width();
    p     = check_bits(n);
    pmask = CHK_W'((1 << p) - 1);
    pick  = $urandom_range(99);
    if (pick < 20) begin
      send_word(KIND_ENCODE, d, CHK_W'($urandom));
    end else begin
      c = encode_checks(d) ^ (CHK_W'($urandom) & ~pmask);
      if (pick < 40) begin
        // clean word
      end else if (pick < 65) begin
        d[$urandom_range(n - 1)] ^= 1'b1;
      end else if (pick < 80) begin
        c[$urandom_range(p - 1)] ^= 1'b1;
      end else if (pick < 88) begin
        d[$urandom_range(n - 1)] ^= 1'b1;
        c[$urandom_range(p - 1)] ^= 1'b1;
      end else begin
        c = CHK_W'($urandom);
      end
      send_word(KIND_CHECK, d, c);
    end
  endtask

  task automatic test_reset_width();
    logic [DATA_W-1:0] d;
    send_word(KIND_ENCODE, '0, '0);
    send_word(KIND_ENCODE, '1, '1);
    d = 57'h0a5;
    send_word(KIND_CHECK, d, encode_checks(d));
    send_word(KIND_CHECK, d ^ 57'h4, encode_checks(d));
    send_word(KIND_CHECK, d, encode_checks(d) ^ 6'h02);
    drain_results();
  endtask

  task automatic test_width_limits();
    logic [DATA_W-1:0] d;
    // zero acts as a single data bit
    write_data_width(6'd0);
    send_word(KIND_ENCODE, '1, '0);
    send_word(KIND_CHECK, '1, 6'h3f);
    drain_results();
    write_data_width(6'd57);
    send_word(KIND_ENCODE, '0, '0);
    send_word(KIND_ENCODE, '1, '0);
    d = '1;
    send_word(KIND_CHECK, d ^ (57'd1 << 56), encode_checks(d));
    send_word(KIND_CHECK, d, 6'h3f);
    drain_results();
    // above the maximum acts as the maximum
    write_data_width(6'd63);
    send_word(KIND_ENCODE, '1, '1);
    send_word(KIND_CHECK, '1, encode_checks('1));
    drain_results();
    // two data bits: five positions, three check bits, syndromes 6 and 7 lie outside
    write_data_width(6'd2);
    send_word(KIND_CHECK, '0, 6'h3e);
    send_word(KIND_CHECK, '0, 6'h07);
    drain_results();
  endtask

  task automatic test_back_to_back();
    write_data_width(6'd57);
    steady = 1'b1;
    repeat (150) send_random_word();
    drain_results();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] widths[12];
    widths = '{6'd1, 6'd2, 6'd3, 6'd5, 6'd11, 6'd12, 6'd26, 6'd27, 6'd56, 6'd63,
               6'd4, 6'd0};
    foreach (widths[i]) begin
      write_data_width(($urandom_range(3) == 0) ? CFG_W'($urandom) : widths[i]);
      repeat (80) send_random_word();
      drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_width();
    test_width_limits();
    test_back_to_back();
    test_random_traffic();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
